// ===== hw/rtl/pbtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtd_pkg
// Shared widths, register decode and control types of the packet buffer.
// ----------------------------------------------------------------------------
package pbtd_pkg;

	localparam int unsigned ARR_W   = 32;
	localparam int unsigned DUR_W   = 16;
	localparam int unsigned TIME_W  = 40;
	localparam int unsigned LIMIT_W = 7;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	// register index as decoded from paddr[2]
	localparam logic REG_BUFFER_LIMIT = 1'b0;

	localparam logic [LIMIT_W-1:0] BUFFER_LIMIT_RST = 7'd64;

	typedef logic [TIME_W-1:0] time_t;

	typedef struct packed {
		logic pop;
		logic push;
	} chain_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

endpackage

// ===== hw/rtl/pbtd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtd_in_if
// Packet channel: arrival tick and processing duration.
// ----------------------------------------------------------------------------
interface pbtd_in_if;
	logic                       valid;
	logic                       ready;
	logic [pbtd_pkg::ARR_W-1:0] arrival_time;
	logic [pbtd_pkg::DUR_W-1:0] duration;

	modport source (output valid, output arrival_time, output duration, input ready);
	modport sink   (input valid, input arrival_time, input duration, output ready);
endinterface

// ===== hw/rtl/pbtd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtd_out_if
// Result channel: drop flag and start tick.
// ----------------------------------------------------------------------------
interface pbtd_out_if;
	logic                        valid;
	logic                        ready;
	logic                        dropped;
	logic [pbtd_pkg::TIME_W-1:0] start_tick;

	modport source (output valid, output dropped, output start_tick, input ready);
	modport sink   (input valid, input dropped, input start_tick, output ready);
endinterface

// ===== hw/rtl/pbtd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtd_cfg
// APB register slave holding the buffer limit.
// ----------------------------------------------------------------------------
module pbtd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pbtd_pkg::APB_AW-1:0]  paddr,
	input  logic [pbtd_pkg::APB_DW-1:0]  pwdata,
	output logic [pbtd_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output logic [pbtd_pkg::LIMIT_W-1:0] buffer_limit
);

	logic [pbtd_pkg::LIMIT_W-1:0] limit_q;
	logic                         sel_limit;

	assign sel_limit = (paddr[2] == pbtd_pkg::REG_BUFFER_LIMIT);
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pbtd_pkg::BUFFER_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			limit_q <= pwdata[pbtd_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata[pbtd_pkg::LIMIT_W-1:0] = limit_q;
		end
	end

	assign buffer_limit = limit_q;

endmodule

// ===== hw/rtl/pbtd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtd_cell
// One buffer slot: takes its neighbor's finish tick on a retire, or the new
// finish tick when it is the tail slot on a push.
// ----------------------------------------------------------------------------
module pbtd_cell #(
	parameter int unsigned CW    = 7,
	parameter int unsigned INDEX = 0
) (
	input  logic                  clk,
	input  pbtd_pkg::chain_ctrl_t ctrl,
	input  logic [CW-1:0]         occ,
	input  pbtd_pkg::time_t       next_val,
	input  pbtd_pkg::time_t       push_val,
	output pbtd_pkg::time_t       val
);

	pbtd_pkg::time_t val_q;
	logic            push_here;

	assign push_here = ctrl.push && (occ == CW'(INDEX));

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= next_val;
		end else if (push_here) begin
			val_q <= push_val;
		end
	end

	assign val = val_q;

endmodule

// ===== hw/rtl/pbtd_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbtd_chain
// Row of slots with the head at slot 0; a retire shifts every slot one place
// toward the head.
// ----------------------------------------------------------------------------
module pbtd_chain #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned CW    = 7
) (
	input  logic                  clk,
	input  pbtd_pkg::chain_ctrl_t ctrl,
	input  logic [CW-1:0]         occ,
	input  pbtd_pkg::time_t       push_val,
	output pbtd_pkg::time_t       head
);

	pbtd_pkg::time_t slot_val [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		pbtd_pkg::time_t nbr;
		if (i == DEPTH - 1) begin : g_last
			assign nbr = slot_val[i];
		end else begin : g_mid
			assign nbr = slot_val[i+1];
		end
		pbtd_cell #(
			.CW    (CW),
			.INDEX (i)
		) u_slot (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (occ),
			.next_val (nbr),
			.push_val (push_val),
			.val      (slot_val[i])
		);
	end

	assign head = slot_val[0];

endmodule

// ===== hw/rtl/packet_buffer_tail_drop_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_buffer_tail_drop_timer
// Tail-drop packet buffer timing: retires finished packets, then drops or
// schedules the arriving packet and reports its start tick.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid/ready     arrival_time[31:0], duration[15:0]
//   out_ch    out  valid/ready     dropped, start_tick[39:0]
//   apb       in   psel/penable    buffer_limit at byte address 0
//
// A packet first retires, one at a time, the buffer entries whose finish
// tick is not after its arrival tick, then takes a decision; the next
// packet is taken in that decision cycle. The retire loop reads the head
// slot of the chain. The decision waits while the result register
// is full and not taken. Reset clears the control state and sets the limit
// to 64; the slot contents are only read once written.
// ----------------------------------------------------------------------------
module packet_buffer_tail_drop_timer #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pbtd_in_if.sink                     in_ch,
	pbtd_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pbtd_pkg::APB_AW-1:0] paddr,
	input  logic [pbtd_pkg::APB_DW-1:0] pwdata,
	output logic [pbtd_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned LW = (CW > pbtd_pkg::LIMIT_W) ? CW : pbtd_pkg::LIMIT_W;

	pbtd_pkg::state_t             state_q;
	logic [pbtd_pkg::ARR_W-1:0]   arrival_q;
	logic [pbtd_pkg::DUR_W-1:0]   duration_q;
	logic [CW-1:0]                occ_q;
	pbtd_pkg::time_t              last_finish_q;
	logic                         out_valid_q;
	logic                         out_dropped_q;
	pbtd_pkg::time_t              out_start_q;

	logic [pbtd_pkg::LIMIT_W-1:0] buffer_limit;
	logic [LW-1:0]                limit_ext;
	logic [LW-1:0]                limit_eff;
	pbtd_pkg::chain_ctrl_t        ctrl;
	pbtd_pkg::time_t              head;
	pbtd_pkg::time_t              arrival_ext;
	pbtd_pkg::time_t              start;
	logic [pbtd_pkg::TIME_W:0]    finish_sum;
	pbtd_pkg::time_t              finish;
	logic                         working;
	logic                         head_done;
	logic                         out_free;
	logic                         decide;
	logic                         drop;
	logic                         accept;

	pbtd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.buffer_limit (buffer_limit)
	);

	// a limit above the depth acts as the depth
	assign limit_ext = LW'(buffer_limit);
	assign limit_eff = (limit_ext > LW'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH) : limit_ext;

	assign arrival_ext = pbtd_pkg::TIME_W'(arrival_q);
	assign working     = (state_q == pbtd_pkg::ST_WORK);
	assign head_done   = (occ_q != '0) && (head <= arrival_ext);
	assign out_free    = !out_valid_q || out_ch.ready;
	assign decide      = working && !head_done && out_free;
	assign drop        = (LW'(occ_q) >= limit_eff);

	assign ctrl.pop  = working && head_done;
	assign ctrl.push = decide && !drop;

	assign start      = (arrival_ext > last_finish_q) ? arrival_ext : last_finish_q;
	assign finish_sum = {1'b0, start} + (pbtd_pkg::TIME_W + 1)'(duration_q);
	// saturate the finish tick at the top of the time range
	assign finish     = finish_sum[pbtd_pkg::TIME_W] ? '1
	                                                 : finish_sum[pbtd_pkg::TIME_W-1:0];

	pbtd_chain #(
		.DEPTH (BUFFER_DEPTH),
		.CW    (CW)
	) u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.occ      (occ_q),
		.push_val (finish),
		.head     (head)
	);

	assign in_ch.ready = (state_q == pbtd_pkg::ST_IDLE) || decide;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pbtd_pkg::ST_IDLE;
			occ_q         <= '0;
			last_finish_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= pbtd_pkg::ST_WORK;
			end else if (decide) begin
				state_q <= pbtd_pkg::ST_IDLE;
			end
			if (ctrl.pop) begin
				occ_q <= occ_q - CW'(1);
			end else if (ctrl.push) begin
				occ_q <= occ_q + CW'(1);
			end
			if (ctrl.push) begin
				last_finish_q <= finish;
			end
			if (decide) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the transaction payload while it is worked on or waits at the output
	always_ff @(posedge clk) begin
		if (accept) begin
			arrival_q  <= in_ch.arrival_time;
			duration_q <= in_ch.duration;
		end
		if (decide) begin
			out_dropped_q <= drop;
			out_start_q   <= drop ? '0 : start;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.dropped    = out_dropped_q;
	assign out_ch.start_tick = out_start_q;

endmodule
